FILE: design/vfc_pkg.sv
// Package: shared types, command codes and helpers for the VRAM fill/copy engine.
package vfc_pkg;

	localparam int STORE_WIDTH_DEF  = 1024;
	localparam int STORE_HEIGHT_DEF = 512;
	localparam logic [15:0] MASK_BIT = 16'h8000;

	typedef enum logic [2:0] {
		CMD_FILL       = 3'd0,
		CMD_COPY       = 3'd1,
		CMD_LOAD_START = 3'd2,
		CMD_LOAD_WORD  = 3'd3,
		CMD_READ_START = 3'd4,
		CMD_READ_WORD  = 3'd5,
		CMD_CANCEL     = 3'd6,
		CMD_NONE       = 3'd7
	} cmd_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FILL,
		ST_CP_RD,
		ST_CP_WAIT,
		ST_CP_CHK,
		ST_LD_RD,
		ST_LD_WAIT,
		ST_LD_WR,
		ST_RD_RD,
		ST_RD_WAIT,
		ST_RD_TAKE,
		ST_OUT
	} state_t;

	localparam logic [0:0] REG_CHECK_MASK = 1'b0;
	localparam logic [0:0] REG_SET_MASK   = 1'b1;

	// 24-bit RGB to 15-bit colour
	function automatic logic [15:0] rgb_to_15(input logic [23:0] rgb);
		rgb_to_15 = {1'b0, rgb[23:19], rgb[15:11], rgb[7:3]};
	endfunction

endpackage

FILE: design/vram_fill_copy_transfer_engine_top.sv
// Top level: VRAM fill, copy, load and readback engine over one pixel RAM.
//
// The engine owns a STORE_WIDTH x STORE_HEIGHT store of 16-bit pixels behind
// a single-port RAM. It takes one command request at a time on the s_axis
// side and returns exactly one result request per command on m_axis. After
// reset it sweeps the whole store to zero, one pixel per cycle, before it
// takes the first command. A sequencer drives the RAM port. Fill writes its
// pixels back to back; copy reads the source, reads the dest, then does a
// masked write; load word does read-check-write per pixel and read word
// does read, wait and take per fetch, each for up to two pixels; starts and
// cancel go straight to the result, which ST_OUT presents. s_axis_tready is
// low while a command is at work or a result waits.
// tdata in: command[2:0], fill_color[26:3], src_x[36:27], src_y[45:37],
// dst_x[55:46], dst_y[64:56], width_raw[80:65], height_raw[96:81],
// data_word[128:97]. tdata out: read_data[31:0], read_valid[32],
// load_pending[33], read_pending[34].
module vram_fill_copy_transfer_engine_top
	import vfc_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// command, fill_color, src_x, src_y, dst_x, dst_y, width_raw, height_raw, data_word
	input  logic [135:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// read_data, read_valid, load_pending, read_pending
	output logic [39:0]  m_axis_tdata,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [0:0]   cfg_wdata
);
	localparam int STORE_WIDTH  = STORE_WIDTH_DEF;
	localparam int STORE_HEIGHT = STORE_HEIGHT_DEF;
	localparam int XW = $clog2(STORE_WIDTH);
	localparam int YW = $clog2(STORE_HEIGHT);
	localparam int AW = XW + YW;
	localparam int WW = XW + 1;
	localparam int HW = YW + 1;
	localparam int PW = WW + HW;
	localparam int DEPTH = STORE_WIDTH * STORE_HEIGHT;
	localparam logic [XW-1:0] XMAX = XW'(STORE_WIDTH - 1);
	localparam logic [YW-1:0] YMAX = YW'(STORE_HEIGHT - 1);

	// field unpack
	logic [2:0]  in_cmd;
	logic [23:0] in_rgb;
	logic [9:0]  in_sx, in_dx;
	logic [8:0]  in_sy, in_dy;
	logic [15:0] in_wr, in_hr;
	logic [31:0] in_word;
	assign in_cmd  = s_axis_tdata[2:0];
	assign in_rgb  = s_axis_tdata[26:3];
	assign in_sx   = s_axis_tdata[36:27];
	assign in_sy   = s_axis_tdata[45:37];
	assign in_dx   = s_axis_tdata[55:46];
	assign in_dy   = s_axis_tdata[64:56];
	assign in_wr   = s_axis_tdata[80:65];
	assign in_hr   = s_axis_tdata[96:81];
	assign in_word = s_axis_tdata[128:97];

	// normalised sizes; store dims are powers of two so mod is a mask
	logic [15:0]   wr_m1, hr_m1;
	logic [WW-1:0] n_w, f_w;
	logic [HW-1:0] n_h, f_h;
	logic [XW-1:0] wr_mod;
	assign wr_m1  = in_wr - 16'd1;
	assign hr_m1  = in_hr - 16'd1;
	assign n_w    = {1'b0, wr_m1[XW-1:0]} + WW'(1);
	assign n_h    = {1'b0, hr_m1[YW-1:0]} + HW'(1);
	assign wr_mod = in_wr[XW-1:0];
	assign f_w    = ({1'b0, wr_mod} + WW'(15)) & ~WW'(15);
	assign f_h    = {1'b0, in_hr[YW-1:0]};

	state_t state_q, state_d;
	logic chk_q, set_q;

	// operation registers
	logic [XW-1:0] ox_q, sx_q;
	logic [YW-1:0] oy_q, sy_q;
	logic [WW-1:0] w_q, col_q;
	logic [HW-1:0] h_q, row_q;
	logic [15:0]   color_q, pix_q;
	logic [31:0]   word_q;
	logic          half_q;
	logic [AW-1:0] clr_q;

	// transfer state
	logic          ld_act_q, rd_act_q;
	logic [XW-1:0] ld_ox_q, ld_x_q, rd_ox_q;
	logic [WW-1:0] ld_w_q, ld_col_q, rd_w_q, rd_col_q;
	logic [YW-1:0] ld_y_q, rd_y_q;
	logic [PW-1:0] ld_left_q, rd_left_q;
	logic [31:0]   rdata_q;
	logic          rvalid_q;

	// RAM port
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_wdata, ram_rdata;

	vfc_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	logic in_acc;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata  = {5'd0, rd_act_q, ld_act_q, rvalid_q, rdata_q};

	logic [XW-1:0] cx_src, cx_dst, rd_x;
	logic [YW-1:0] cy_src, cy_dst;
	assign cx_src = sx_q + col_q[XW-1:0];
	assign cy_src = sy_q + row_q[YW-1:0];
	assign cx_dst = ox_q + col_q[XW-1:0];
	assign cy_dst = oy_q + row_q[YW-1:0];
	assign rd_x   = rd_ox_q + rd_col_q[XW-1:0];

	logic last_col, last_row;
	assign last_col = (col_q + WW'(1) >= w_q);
	assign last_row = (row_q + HW'(1) >= h_q);

	logic [15:0] ld_pix;
	assign ld_pix = half_q ? word_q[31:16] : word_q[15:0];

	logic masked;
	assign masked = chk_q && ram_rdata[15];

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_addr  = {cy_dst, cx_dst};
		ram_wdata = color_q;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we   = 1'b1;
				ram_addr = clr_q;
				ram_wdata = 16'd0;
				if (clr_q == AW'(DEPTH - 1)) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_acc) begin
					case (in_cmd)
						CMD_FILL:       state_d = (f_w == '0 || f_h == '0) ? ST_OUT : ST_FILL;
						CMD_COPY:       state_d = ST_CP_RD;
						CMD_LOAD_WORD:  state_d = (ld_act_q && ld_left_q != '0) ? ST_LD_RD : ST_OUT;
						CMD_READ_WORD:  state_d = rd_act_q ? ST_RD_RD : ST_OUT;
						default:        state_d = ST_OUT;
					endcase
				end
			end
			ST_FILL: begin
				ram_we = 1'b1;
				if (last_col && last_row) state_d = ST_OUT;
			end
			ST_CP_RD: begin
				ram_addr = {cy_src, cx_src};
				state_d  = ST_CP_WAIT;
			end
			ST_CP_WAIT: begin
				state_d = ST_CP_CHK;
			end
			ST_CP_CHK: begin
				// dest read is registered now in ram_rdata
				ram_we    = !masked;
				ram_wdata = pix_q | (set_q ? MASK_BIT : 16'd0);
				state_d   = (last_col && last_row) ? ST_OUT : ST_CP_RD;
			end
			ST_LD_RD: begin
				ram_addr = {ld_y_q, ld_x_q};
				state_d  = ST_LD_WAIT;
			end
			ST_LD_WAIT: begin
				ram_addr = {ld_y_q, ld_x_q};
				state_d  = ST_LD_WR;
			end
			ST_LD_WR: begin
				ram_addr  = {ld_y_q, ld_x_q};
				ram_we    = !masked;
				ram_wdata = ld_pix | (set_q ? MASK_BIT : 16'd0);
				state_d   = (!half_q && ld_left_q != PW'(1)) ? ST_LD_RD : ST_OUT;
			end
			ST_RD_RD: begin
				ram_addr = {rd_y_q, rd_x};
				state_d  = ST_RD_WAIT;
			end
			ST_RD_WAIT: begin
				ram_addr = {rd_y_q, rd_x};
				state_d  = ST_RD_TAKE;
			end
			ST_RD_TAKE: begin
				ram_addr = {rd_y_q, rd_x};
				state_d  = (!half_q && rd_left_q != PW'(1)) ? ST_RD_RD : ST_OUT;
			end
			ST_OUT: begin
				if (m_axis_tready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= '0;
			chk_q     <= 1'b0;
			set_q     <= 1'b0;
			ld_act_q  <= 1'b0;
			rd_act_q  <= 1'b0;
			ld_ox_q   <= '0;
			ld_x_q    <= '0;
			ld_y_q    <= '0;
			ld_w_q    <= '0;
			ld_col_q  <= '0;
			ld_left_q <= '0;
			rd_ox_q   <= '0;
			rd_y_q    <= '0;
			rd_w_q    <= '0;
			rd_col_q  <= '0;
			rd_left_q <= '0;
			rvalid_q  <= 1'b0;
			rdata_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_index == REG_CHECK_MASK) chk_q <= cfg_wdata[0];
				if (cfg_index == REG_SET_MASK)   set_q <= cfg_wdata[0];
			end
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_IDLE: if (in_acc) begin
					rvalid_q <= (in_cmd == CMD_READ_WORD) && rd_act_q;
					rdata_q  <= '0;
					case (in_cmd)
						CMD_LOAD_START: begin
							ld_w_q    <= n_w;
							ld_left_q <= PW'(n_w) * PW'(n_h);
							ld_ox_q   <= in_dx[XW-1:0];
							ld_x_q    <= in_dx[XW-1:0];
							ld_y_q    <= in_dy[YW-1:0];
							ld_col_q  <= '0;
							ld_act_q  <= 1'b1;
						end
						CMD_READ_START: begin
							rd_w_q    <= n_w;
							rd_left_q <= PW'(n_w) * PW'(n_h);
							rd_ox_q   <= in_sx[XW-1:0];
							rd_y_q    <= in_sy[YW-1:0];
							rd_col_q  <= '0;
							rd_act_q  <= 1'b1;
						end
						CMD_CANCEL: begin
							ld_act_q <= 1'b0;
							rd_act_q <= 1'b0;
						end
						default: ;
					endcase
				end
				ST_LD_WR: begin
					if (ld_col_q + WW'(1) >= ld_w_q) begin
						ld_col_q <= '0;
						ld_x_q   <= ld_ox_q;
						ld_y_q   <= (ld_y_q == YMAX) ? '0 : ld_y_q + YW'(1);
					end else begin
						ld_col_q <= ld_col_q + WW'(1);
						ld_x_q   <= (ld_x_q == XMAX) ? '0 : ld_x_q + XW'(1);
					end
					ld_left_q <= ld_left_q - PW'(1);
					if (ld_left_q == PW'(1)) ld_act_q <= 1'b0;
				end
				ST_RD_TAKE: begin
					if (half_q) rdata_q[31:16] <= ram_rdata;
					else        rdata_q[15:0]  <= ram_rdata;
					if (rd_col_q + WW'(1) >= rd_w_q) begin
						rd_col_q <= '0;
						rd_y_q   <= (rd_y_q == YMAX) ? '0 : rd_y_q + YW'(1);
					end else begin
						rd_col_q <= rd_col_q + WW'(1);
					end
					rd_left_q <= rd_left_q - PW'(1);
					if (half_q || rd_left_q == PW'(1)) begin
						if (rd_left_q == PW'(1)) rd_act_q <= 1'b0;
					end
				end
				ST_OUT: if (rd_left_q == '0) rd_act_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// payload registers for the active operation
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_acc) begin
			col_q   <= '0;
			row_q   <= '0;
			half_q  <= 1'b0;
			color_q <= rgb_to_15(in_rgb);
			word_q  <= in_word;
			sx_q    <= in_sx[XW-1:0];
			sy_q    <= in_sy[YW-1:0];
			if (in_cmd == CMD_FILL) begin
				ox_q <= in_dx[XW-1:0] & ~XW'(15);
				w_q  <= f_w;
				h_q  <= f_h;
			end else begin
				ox_q <= in_dx[XW-1:0];
				w_q  <= n_w;
				h_q  <= n_h;
			end
			oy_q <= in_dy[YW-1:0];
		end else if (state_q == ST_CP_WAIT) begin
			pix_q <= ram_rdata;
		end else if (state_q == ST_FILL || state_q == ST_CP_CHK) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q + HW'(1);
			end else begin
				col_q <= col_q + WW'(1);
			end
		end else if (state_q == ST_LD_WR || state_q == ST_RD_TAKE) begin
			half_q <= 1'b1;
		end
	end

	// copy: CP_WAIT reads source data, then the dest must be read for the
	// mask test; the dest address is presented during CP_WAIT
	// (default ram_addr) so CP_CHK sees the dest pixel.
endmodule

FILE: design/vfc_ram.sv
// Generic single-port RAM with registered read.
module vfc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: design/vfc_checker.sv
// Port-level checker for the VRAM engine, bound to the top level.
module vfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);
	a_no_ready_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped or changed");
	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[32] |-> m_axis_tdata[31:0] == 32'd0)
		else $error("read data not zero");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
endmodule

bind vram_fill_copy_transfer_engine_top vfc_checker u_vfc_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);

FILE: test/testbench.sv
// Testbench: self-checking stimulus and pixel store predictor for the VRAM fill/copy engine.
//
// Directed requests from a table (the result is typed in where obvious),
// then random request sequences with random stalls on both stream sides.
// A shadow pixel store and transfer state predict the results not typed in;
// each result request is compared field by field against the oldest expectation.
module testbench
	import vfc_pkg::*;
();

	localparam int SW = STORE_WIDTH_DEF;
	localparam int SH = STORE_HEIGHT_DEF;
	localparam longint CYCLE_LIMIT = 8_000_000;	// includes the clear sweep

	// packed lowest field last, so cmd lands in the low bits of tdata
	typedef struct packed {
		logic [31:0]  word;
		logic [15:0]  h_raw;
		logic [15:0]  w_raw;
		logic [8:0]   dy;
		logic [9:0]   dx;
		logic [8:0]   sy;
		logic [9:0]   sx;
		logic [23:0]  color;
		cmd_t         cmd;
	} req_t;

	// {read_pending, load_pending, read_valid, read_data}
	typedef logic [34:0] res_t;

	typedef struct {
		req_t rq;
		bit   typed;
		res_t res;
	} row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [135:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic         cfg_we;
	logic [0:0]   cfg_index;
	logic [0:0]   cfg_wdata;

	vram_fill_copy_transfer_engine_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the pixel store and the transfer state
	logic [15:0] vram [0:SW*SH-1];
	bit  chk_mask, mask_force;
	bit  ld_on, rd_on;
	int  ld_org_x, ld_w, ld_col, ld_x, ld_y, ld_left;
	int  rd_org_x, rd_w, rd_col, rd_y, rd_left;

	res_t results_due[$];
	int   fail_count;
	longint cycles;
	bit   calm;			// no idling on either side
	bit   req_typed;	// typed expectation travels with the request
	res_t req_res;

	function automatic int pix(int x, int y);
		return (y % SH) * SW + (x % SW);
	endfunction

	function automatic int norm_size(logic [15:0] raw, int lim);
		logic [15:0] t;
		t = raw - 16'd1;
		return int'(t) % lim + 1;
	endfunction

	task automatic masked_write(int a, logic [15:0] v);
		if (chk_mask && vram[a][15])
			return;
		vram[a] = v | (mask_force ? MASK_BIT : 16'h0);
	endtask

	task automatic load_pixel(logic [15:0] v);
		if (!ld_on || ld_left == 0)
			return;
		masked_write(pix(ld_x, ld_y), v);
		ld_col++;
		ld_x = (ld_x + 1) % SW;
		if (ld_col >= ld_w) begin
			ld_col = 0;
			ld_x = ld_org_x;
			ld_y = (ld_y + 1) % SH;
		end
		ld_left--;
		if (ld_left == 0)
			ld_on = 0;
	endtask

	task automatic fetch_pixel(output logic [15:0] v);
		v = 16'h0;
		if (!rd_on || rd_left == 0)
			return;
		v = vram[pix(rd_org_x + rd_col, rd_y)];
		rd_col++;
		if (rd_col >= rd_w) begin
			rd_col = 0;
			rd_y = (rd_y + 1) % SH;
		end
		rd_left--;
	endtask

	task automatic predict_engine(input req_t r, output res_t res);
		logic [15:0] c, lo, hi;
		logic [31:0] rdata;
		bit rvalid;
		int w, h, x0;
		rdata = '0;
		rvalid = 0;
		case (r.cmd)
			CMD_FILL: begin
				c = {1'b0, r.color[23:19], r.color[15:11], r.color[7:3]};
				x0 = int'(r.dx) & ~32'hf;
				w = ((int'(r.w_raw) % SW) + 15) & ~32'hf;
				h = int'(r.h_raw) % SH;
				for (int y = 0; y < h; y++)
					for (int x = 0; x < w; x++)
						vram[pix(x0 + x, r.dy + y)] = c;
			end
			CMD_COPY: begin
				w = norm_size(r.w_raw, SW);
				h = norm_size(r.h_raw, SH);
				for (int y = 0; y < h; y++)
					for (int x = 0; x < w; x++)
						masked_write(pix(r.dx + x, r.dy + y), vram[pix(r.sx + x, r.sy + y)]);
			end
			CMD_LOAD_START: begin
				ld_w = norm_size(r.w_raw, SW);
				ld_left = ld_w * norm_size(r.h_raw, SH);
				ld_org_x = r.dx;
				ld_x = r.dx;
				ld_y = r.dy;
				ld_col = 0;
				ld_on = 1;
			end
			CMD_LOAD_WORD: begin
				if (ld_on) begin
					load_pixel(r.word[15:0]);
					load_pixel(r.word[31:16]);
				end
			end
			CMD_READ_START: begin
				rd_w = norm_size(r.w_raw, SW);
				rd_left = rd_w * norm_size(r.h_raw, SH);
				rd_org_x = r.sx;
				rd_y = r.sy;
				rd_col = 0;
				rd_on = 1;
			end
			CMD_READ_WORD: begin
				if (rd_on) begin
					fetch_pixel(lo);
					fetch_pixel(hi);
					rdata = {hi, lo};
					rvalid = 1;
					if (rd_left == 0)
						rd_on = 0;
				end
			end
			CMD_CANCEL: begin
				ld_on = 0;
				rd_on = 0;
			end
			default: ;
		endcase
		res = {rd_on, ld_on, rvalid, rdata};
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
		fail_count++;
	endtask

	// request side: predict at acceptance; result side: compare in order
	always @(posedge clk) begin
		res_t want;
		res_t got;
		if (arst_n && s_axis_tvalid && s_axis_tready) begin
			predict_engine(req_t'(s_axis_tdata[128:0]), want);
			results_due.push_back(req_typed ? req_res : want);
		end
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata[34:0];
			if (results_due.size() == 0) begin
				report("unexpected result", got[31:0], 32'h0);
			end else begin
				want = results_due.pop_front();
				if (got[31:0] !== want[31:0])
					report("read_data", got[31:0], want[31:0]);
				if (got[32] !== want[32])
					report("read_valid", got[32], want[32]);
				if (got[33] !== want[33])
					report("load_pending", got[33], want[33]);
				if (got[34] !== want[34])
					report("read_pending", got[34], want[34]);
			end
		end
	end

	// result side stalls
	always @(posedge clk)
		m_axis_tready <= calm ? 1'b1 : ($urandom_range(99) >= 29);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic send(req_t r, bit typed = 0, res_t res = '0);
		if (!calm && $urandom_range(99) < 29) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {7'b0, r};
		req_typed <= typed;
		req_res <= res;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// step past the acceptance edge first so the last accepted request is already queued
	task automatic drain;
		s_axis_tvalid <= 1'b0;
		req_typed <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(logic [0:0] idx, bit v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_CHECK_MASK)
			chk_mask = v;
		else
			mask_force = v;
	endtask

	function automatic req_t noise_req(cmd_t c);
		req_t r;
		r.cmd = c;
		r.color = 24'($urandom);
		r.sx = 10'($urandom);
		r.sy = 9'($urandom);
		r.dx = 10'($urandom);
		r.dy = 9'($urandom);
		r.w_raw = 16'($urandom);
		r.h_raw = 16'($urandom);
		r.word = $urandom;
		return r;
	endfunction

	function automatic req_t mk(cmd_t c, int sx, int sy, int dx, int dy, int w, int h,
			logic [23:0] color = 24'h0, logic [31:0] word = 32'h0);
		req_t r;
		r.cmd = c;
		r.color = color;
		r.sx = 10'(sx);
		r.sy = 9'(sy);
		r.dx = 10'(dx);
		r.dy = 9'(dy);
		r.w_raw = 16'(w);
		r.h_raw = 16'(h);
		r.word = word;
		return r;
	endfunction

	// small sizes with random aliasing in the upper raw bits
	function automatic logic [15:0] alias_w(int n);
		return 16'(n + SW * $urandom_range(0, 63));
	endfunction
	function automatic logic [15:0] alias_h(int n);
		return 16'(n + SH * $urandom_range(0, 127));
	endfunction

	// one random request sequence; returns how many requests it held
	task automatic random_sequence(output int n);
		req_t r;
		int w, h, words, kind;
		n = 0;
		kind = $urandom_range(99);
		if (kind < 30) begin
			// load transfer, now and then cut short
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 4);
			r = noise_req(CMD_LOAD_START);
			r.w_raw = alias_w(w);
			r.h_raw = alias_h(h);
			send(r);
			n++;
			words = (w * h + 1) / 2;
			if ($urandom_range(9) == 0)
				words = $urandom_range(0, words);
			repeat (words) begin
				send(noise_req(CMD_LOAD_WORD));
				n++;
			end
		end else if (kind < 58) begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 4);
			r = noise_req(CMD_READ_START);
			r.w_raw = alias_w(w);
			r.h_raw = alias_h(h);
			send(r);
			n++;
			words = (w * h + 1) / 2;
			if ($urandom_range(9) == 0)
				words = $urandom_range(0, words + 2);
			repeat (words) begin
				send(noise_req(CMD_READ_WORD));
				n++;
			end
		end else if (kind < 72) begin
			r = noise_req(CMD_FILL);
			r.w_raw = alias_w($urandom_range(0, 40));
			r.h_raw = 16'($urandom_range(0, 6) + SH * $urandom_range(0, 127));
			send(r);
			n++;
		end else if (kind < 88) begin
			r = noise_req(CMD_COPY);
			r.w_raw = alias_w($urandom_range(1, 20));
			r.h_raw = alias_h($urandom_range(1, 6));
			send(r);
			n++;
		end else begin
			// noise: stray words, cancel, unused code
			case ($urandom_range(3))
				0: r = noise_req(CMD_LOAD_WORD);
				1: r = noise_req(CMD_READ_WORD);
				2: r = noise_req(CMD_CANCEL);
				default: r = noise_req(CMD_NONE);
			endcase
			send(r);
			n++;
		end
	endtask

	localparam res_t RES_IDLE = '0;
	localparam res_t RES_LOAD = 35'h2_0000_0000;
	localparam res_t RES_READ = 35'h4_0000_0000;

	row_t directed [$];

	initial begin
		int sent, n;
		bit modes [5][2];
		modes = '{'{0, 0}, '{1, 0}, '{0, 1}, '{1, 1}, '{0, 0}};
		clk = 1'b0;
		for (int i = 0; i < SW * SH; i++)
			vram[i] = 16'h0;
		chk_mask = 0;
		mask_force = 0;
		ld_on = 0;
		rd_on = 0;
		fail_count = 0;
		cycles = 0;
		calm = 0;
		req_typed = 0;
		req_res = '0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed = '{
			// read word with nothing pending, store still clear
			'{mk(CMD_READ_WORD, 0, 0, 0, 0, 0, 0), 1, RES_IDLE},
			'{mk(CMD_CANCEL, 0, 0, 0, 0, 0, 0), 1, RES_IDLE},
			'{mk(CMD_NONE, 1023, 511, 1023, 511, 65535, 65535, 24'hffffff, '1), 1, RES_IDLE},
			// fill that wraps on both edges, full-width rounding
			'{mk(CMD_FILL, 0, 0, 1023, 511, 65535, 2, 24'hffffff), 1, RES_IDLE},
			'{mk(CMD_FILL, 0, 0, 37, 5, 0, 5, 24'h123456), 1, RES_IDLE},
			'{mk(CMD_FILL, 0, 0, 500, 20, 17, 65535 - 512 * 127, 24'h0807f8), 1, RES_IDLE},
			// read wraps in x, odd tail
			'{mk(CMD_READ_START, 1020, 511, 0, 0, 5, 1), 1, RES_READ},
			'{mk(CMD_READ_WORD, 0, 0, 0, 0, 0, 0), 0, RES_IDLE},
			'{mk(CMD_READ_WORD, 0, 0, 0, 0, 0, 0), 0, RES_IDLE},
			'{mk(CMD_READ_WORD, 0, 0, 0, 0, 0, 0), 0, RES_IDLE},
			'{mk(CMD_READ_WORD, 0, 0, 0, 0, 0, 0), 1, RES_IDLE},
			// load wrapping at the corner, odd tail drops the high halfword
			'{mk(CMD_LOAD_START, 0, 0, 1022, 511, 3, 1), 1, RES_LOAD},
			'{mk(CMD_LOAD_WORD, 0, 0, 0, 0, 0, 0, 0, 32'h8001_7fff), 1, RES_LOAD},
			'{mk(CMD_LOAD_WORD, 0, 0, 0, 0, 0, 0, 0, 32'hdead_beef), 1, RES_IDLE},
			'{mk(CMD_LOAD_WORD, 0, 0, 0, 0, 0, 0, 0, 32'h1234_5678), 1, RES_IDLE},
			// copies: width zero means full width, overlapping shift
			'{mk(CMD_COPY, 0, 511, 5, 0, 0, 1), 0, RES_IDLE},
			'{mk(CMD_COPY, 1, 0, 0, 0, 65535, 2), 0, RES_IDLE},
			'{mk(CMD_COPY, 1020, 510, 1022, 511, 6, 3), 0, RES_IDLE},
			// largest transfers, then replaced or cancelled
			'{mk(CMD_LOAD_START, 0, 0, 0, 0, 0, 0), 1, RES_LOAD},
			'{mk(CMD_READ_START, 0, 0, 0, 0, 0, 0), 1, RES_LOAD | RES_READ},
			'{mk(CMD_READ_WORD, 0, 0, 0, 0, 0, 0), 0, RES_IDLE},
			'{mk(CMD_LOAD_START, 0, 0, 7, 9, 2, 1), 1, RES_LOAD | RES_READ},
			'{mk(CMD_CANCEL, 0, 0, 0, 0, 0, 0), 1, RES_IDLE},
			'{mk(CMD_LOAD_WORD, 0, 0, 0, 0, 0, 0, 0, 32'hffff_ffff), 1, RES_IDLE},
			'{mk(CMD_READ_WORD, 0, 0, 0, 0, 0, 0), 1, RES_IDLE}
		};
		foreach (directed[i])
			send(directed[i].rq, directed[i].typed, directed[i].res);
		drain();

		// random phases, each under its own mask setting
		sent = 0;
		for (int p = 0; p < 5; p++) begin
			write_reg(REG_CHECK_MASK, modes[p][0]);
			write_reg(REG_SET_MASK, modes[p][1]);
			while (sent < 180 * (p + 1)) begin
				calm = (p == 2);
				random_sequence(n);
				sent += n;
			end
			calm = 0;
			drain();
		end

		repeat (20) @(posedge clk);
		if (fail_count == 0 && results_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
